/* src/lru_page_cache_macros.svh */
// assertion macros for the lru page cache
// no dependencies; included by the top level only
`ifndef LRU_PAGE_CACHE_MACROS_SVH
`define LRU_PAGE_CACHE_MACROS_SVH
`ifndef SYNTHESIS
`define LPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lru_page_cache: check failed");
`define LPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru_page_cache: check failed");
`else
`define LPC_ASSERT(lbl, clk, rst_n, prop)
`define LPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/lpc_pkg.sv */
// shared constants for the lru page cache
// no dependencies; used by lru_page_cache
`default_nettype none

package lpc_pkg;

  localparam int PageNumW        = 20;
  localparam int CapW            = 5;
  localparam int OccW            = 5;
  localparam int EntriesDefault  = 16;
  localparam int PageBitsDefault = 20;
  localparam int CapReset        = 16;

endpackage

`default_nettype wire

/* src/lru_page_cache.sv */
// lru page cache: fully associative page table with least recently used replacement
// depends on lpc_pkg and lru_page_cache_macros.svh
//
// One page request is taken on every clock cycle in which start is high; busy is
// never raised. Each request gives exactly one result, shown for one cycle with
// strobe_o high; the request passes through the input register, then through the tag
// compare and rank update into the result register. The receiver cannot stall, so
// results must be taken as they appear. Back-to-back requests see the state left by
// the one before. The capacity register is written through cfg_valid_i / cfg_ready_o;
// the user must write it only while no request is in flight, as the block itself does
// not enforce this; a zero capacity acts as one, a value above ENTRIES as ENTRIES.
`default_nettype none

module lru_page_cache #(
  parameter int ENTRIES   = lpc_pkg::EntriesDefault,
  parameter int PAGE_BITS = lpc_pkg::PageBitsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [lpc_pkg::PageNumW-1:0] page_number_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [lpc_pkg::CapW-1:0]    cfg_data_i,
  output logic                             strobe_o,
  output logic                             hit_o,
  output logic                             evicted_o,
  output logic [lpc_pkg::PageNumW-1:0]     evicted_page_o,
  output logic [lpc_pkg::OccW-1:0]         occupancy_o
);

  `include "lru_page_cache_macros.svh"

  localparam int TagW  = (PAGE_BITS < lpc_pkg::PageNumW) ? PAGE_BITS : lpc_pkg::PageNumW;
  localparam int RankW = $clog2(ENTRIES);
  localparam int CntW  = $clog2(ENTRIES + 1);
  localparam int CmpW  = (CntW > lpc_pkg::CapW) ? CntW : lpc_pkg::CapW;
  localparam logic [CmpW-1:0] EntC = CmpW'(ENTRIES);

  logic [lpc_pkg::CapW-1:0] cap_q;
  logic                     req_valid_q;
  logic [TagW-1:0]          req_page_q;

  logic [TagW-1:0]          tag_q   [ENTRIES];
  logic [RankW-1:0]         rank_q  [ENTRIES];
  logic [RankW-1:0]         rank_d  [ENTRIES];
  logic [ENTRIES-1:0]       valid_q;
  logic [ENTRIES-1:0]       valid_d;
  logic [CntW-1:0]          count_q;
  logic [CntW-1:0]          count_d;

  logic [ENTRIES-1:0]       hit_oh;
  logic [ENTRIES-1:0]       victim_oh;
  logic [ENTRIES-1:0]       free_oh;
  logic [ENTRIES-1:0]       wr_oh;
  logic [RankW-1:0]         found_rank;
  logic [TagW-1:0]          victim_tag;
  logic [CntW-1:0]          count_m1;
  logic [CmpW-1:0]          cap_ext;
  logic [CmpW-1:0]          eff_cap;
  logic [CmpW-1:0]          count_ext;
  logic [CmpW-1:0]          occ_ext;
  logic                     is_hit;
  logic                     do_evict;

  logic                     strobe_q;
  logic                     hit_q;
  logic                     evicted_q;
  logic [TagW-1:0]          evicted_page_q;
  logic [CntW-1:0]          occ_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lpc_pkg::CapW'(lpc_pkg::CapReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_page_q <= page_number_i[TagW-1:0];
    end
  end

  // lookup and victim selection
  always_comb begin
    count_m1   = count_q - CntW'(1);
    found_rank = '0;
    victim_tag = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_oh[i]    = valid_q[i] && (tag_q[i] == req_page_q);
      victim_oh[i] = valid_q[i] && (CntW'(rank_q[i]) == count_m1);
      found_rank   = found_rank | (hit_oh[i] ? rank_q[i] : '0);
      victim_tag   = victim_tag | (victim_oh[i] ? tag_q[i] : '0);
    end
    free_oh = ~valid_q & (valid_q + ENTRIES'(1));

    cap_ext   = CmpW'(cap_q);
    count_ext = CmpW'(count_q);
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > EntC) begin
      eff_cap = EntC;
    end else begin
      eff_cap = cap_ext;
    end

    is_hit   = |hit_oh;
    do_evict = !is_hit && (count_ext >= eff_cap);
    if (is_hit) begin
      wr_oh = '0;
    end else if (do_evict) begin
      wr_oh = victim_oh;
    end else begin
      wr_oh = free_oh;
    end

    valid_d = valid_q | wr_oh;
    count_d = (!is_hit && !do_evict) ? count_q + CntW'(1) : count_q;
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_oh[i] || hit_oh[i]) begin
        rank_d[i] = '0;
      end else if (valid_q[i] && (!is_hit || rank_q[i] < found_rank)) begin
        rank_d[i] = rank_q[i] + RankW'(1);
      end else begin
        rank_d[i] = rank_q[i];
      end
    end
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (req_valid_q) begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (req_valid_q && wr_oh[i]) begin
        tag_q[i] <= req_page_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      hit_q          <= is_hit;
      evicted_q      <= do_evict;
      evicted_page_q <= do_evict ? victim_tag : '0;
      occ_q          <= count_d;
    end
  end

  assign occ_ext        = CmpW'(occ_q);
  assign strobe_o       = strobe_q;
  assign hit_o          = hit_q;
  assign evicted_o      = evicted_q;
  assign evicted_page_o = lpc_pkg::PageNumW'(evicted_page_q);
  assign occupancy_o    = occ_ext[lpc_pkg::OccW-1:0];

  `LPC_ASSERT(a_count_matches_valid, clk_i, rst_ni, $countones(valid_q) == int'(count_q))
  `LPC_ASSERT(a_count_in_range, clk_i, rst_ni, CmpW'(count_q) <= EntC)
  `LPC_ASSERT(a_hit_excludes_evict, clk_i, rst_ni, !(strobe_o && hit_o && evicted_o))
  `LPC_ASSERT_NEXT(a_request_gives_result, clk_i, rst_ni, req_valid_q, strobe_o)

endmodule

`default_nettype wire

/* dv/lru_page_cache_tb.sv */
// self-checking testbench for lru_page_cache: directed table, then random phases
// each phase rewrites the capacity register; depends on lpc_pkg and the rtl only
`default_nettype none

module lru_page_cache_tb;

  localparam int Entries     = lpc_pkg::EntriesDefault;
  localparam int Phases      = 15;
  localparam int PhaseItems  = 90;
  localparam int PoolSize    = 24;
  localparam int DrainCycles = 4;
  localparam int CycleLimit  = 400000;
  localparam int ReportMax   = 10;

  typedef enum logic [0:0] {
    ROW_REF,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    logic                         hit;
    logic                         evicted;
    logic [lpc_pkg::PageNumW-1:0] evicted_page;
    logic [lpc_pkg::OccW-1:0]     occupancy;
  } lookup_result_t;

  typedef struct packed {
    row_kind_e                    kind;
    logic [lpc_pkg::PageNumW-1:0] value;
    logic                         pinned;
    lookup_result_t               res;
  } stim_row_t;

  localparam int DirectedRows = 22;

  // pinned rows carry the result typed in; the rest go through the predictor
  stim_row_t directed_rows [DirectedRows] = '{
    '{ROW_REF, 20'h00000, 1'b1, '{1'b0, 1'b0, 20'h00000, 5'd1}},
    '{ROW_REF, 20'hFFFFF, 1'b1, '{1'b0, 1'b0, 20'h00000, 5'd2}},
    '{ROW_REF, 20'h00000, 1'b1, '{1'b1, 1'b0, 20'h00000, 5'd2}},
    '{ROW_REF, 20'h80000, 1'b1, '{1'b0, 1'b0, 20'h00000, 5'd3}},
    '{ROW_CFG, 20'd3,     1'b0, '0},
    '{ROW_REF, 20'h12345, 1'b1, '{1'b0, 1'b1, 20'hFFFFF, 5'd3}},
    '{ROW_REF, 20'h80000, 1'b1, '{1'b1, 1'b0, 20'h00000, 5'd3}},
    '{ROW_CFG, 20'd0,     1'b0, '0},
    '{ROW_REF, 20'h00001, 1'b1, '{1'b0, 1'b1, 20'h00000, 5'd3}},
    '{ROW_REF, 20'h00002, 1'b1, '{1'b0, 1'b1, 20'h12345, 5'd3}},
    '{ROW_REF, 20'h00001, 1'b1, '{1'b1, 1'b0, 20'h00000, 5'd3}},
    '{ROW_REF, 20'h7FFFF, 1'b1, '{1'b0, 1'b1, 20'h80000, 5'd3}},
    '{ROW_CFG, 20'd31,    1'b0, '0},
    '{ROW_REF, 20'hFFFFF, 1'b1, '{1'b0, 1'b0, 20'h00000, 5'd4}},
    '{ROW_REF, 20'h00000, 1'b1, '{1'b0, 1'b0, 20'h00000, 5'd5}},
    '{ROW_CFG, 20'd1,     1'b0, '0},
    '{ROW_REF, 20'hFFFFF, 1'b1, '{1'b1, 1'b0, 20'h00000, 5'd5}},
    '{ROW_REF, 20'h55555, 1'b1, '{1'b0, 1'b1, 20'h00002, 5'd5}},
    '{ROW_REF, 20'hAAAAA, 1'b1, '{1'b0, 1'b1, 20'h00001, 5'd5}},
    '{ROW_CFG, 20'd16,    1'b0, '0},
    '{ROW_REF, 20'h0F0F0, 1'b0, '0},
    '{ROW_REF, 20'hF0F0F, 1'b0, '0}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [lpc_pkg::PageNumW-1:0] page_number_i;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [lpc_pkg::CapW-1:0]     cfg_data_i;
  logic                         strobe_o;
  logic                         hit_o;
  logic                         evicted_o;
  logic [lpc_pkg::PageNumW-1:0] evicted_page_o;
  logic [lpc_pkg::OccW-1:0]     occupancy_o;

  lru_page_cache u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .page_number_i  (page_number_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .strobe_o       (strobe_o),
    .hit_o          (hit_o),
    .evicted_o      (evicted_o),
    .evicted_page_o (evicted_page_o),
    .occupancy_o    (occupancy_o)
  );

  // predictor state
  logic [lpc_pkg::PageNumW-1:0] tag_mem    [Entries];
  logic                         slot_valid [Entries];
  int unsigned                  age_rank   [Entries];
  int unsigned                  resident;
  logic [lpc_pkg::CapW-1:0]     capacity;

  lookup_result_t               pending_lookups [$];
  logic                         pinned_valid;
  lookup_result_t               pinned_result;
  int                           error_count;
  int                           mismatch_count;
  int                           cycle_count;
  logic [lpc_pkg::PageNumW-1:0] page_pool [PoolSize];

  function automatic lookup_result_t lookup_page(input logic [lpc_pkg::PageNumW-1:0] pg);
    int             found;
    int             slot;
    int unsigned    ecap;
    int unsigned    lim;
    int unsigned    best;
    lookup_result_t r;
    found = -1;
    slot  = -1;
    best  = 0;
    r     = '0;
    ecap  = (capacity == 0) ? 1 : ((capacity > Entries) ? Entries : capacity);
    for (int i = 0; i < Entries; i++) begin
      if (found < 0 && slot_valid[i] && tag_mem[i] == pg) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      lim = age_rank[found];
      for (int i = 0; i < Entries; i++) begin
        if (slot_valid[i] && age_rank[i] < lim) age_rank[i]++;
      end
      age_rank[found] = 0;
    end else begin
      if (resident >= ecap) begin
        for (int i = 0; i < Entries; i++) begin
          if (slot_valid[i] && (slot < 0 || age_rank[i] > best)) begin
            slot = i;
            best = age_rank[i];
          end
        end
        if (slot >= 0) begin
          r.evicted      = 1'b1;
          r.evicted_page = tag_mem[slot];
          slot_valid[slot] = 1'b0;
          age_rank[slot]   = 0;
          resident--;
        end
      end
      if (slot < 0) begin
        for (int i = Entries - 1; i >= 0; i--) begin
          if (!slot_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        for (int i = 0; i < Entries; i++) begin
          if (slot_valid[i]) age_rank[i]++;
        end
        slot_valid[slot] = 1'b1;
        tag_mem[slot]    = pg;
        age_rank[slot]   = 0;
        resident++;
      end
    end
    r.occupancy = resident[lpc_pkg::OccW-1:0];
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result check first, then prediction of the request taken at this edge
  always @(posedge clk_i) begin
    lookup_result_t want;
    lookup_result_t got;
    lookup_result_t calc;
    if (rst_ni) begin
      if (strobe_o) begin
        got = '{hit_o, evicted_o, evicted_page_o, occupancy_o};
        if (pending_lookups.size() == 0) begin
          error_count++;
          if (mismatch_count < ReportMax)
            $display("unexpected result: hit %0b evicted %0b page %h occupancy %0d",
                     got.hit, got.evicted, got.evicted_page, got.occupancy);
          mismatch_count++;
        end else begin
          want = pending_lookups.pop_front();
          if (got !== want) begin
            error_count++;
            if (mismatch_count < ReportMax)
              $display("mismatch: expected hit %0b evicted %0b page %h occupancy %0d, got hit %0b evicted %0b page %h occupancy %0d",
                       want.hit, want.evicted, want.evicted_page, want.occupancy,
                       got.hit, got.evicted, got.evicted_page, got.occupancy);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        calc = lookup_page(page_number_i);
        pending_lookups.push_back(pinned_valid ? pinned_result : calc);
      end
      if (cfg_valid_i && cfg_ready_o) capacity = cfg_data_i;
    end
  end

  task automatic settle_pipeline();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_lookups.size() != 0);
  endtask

  task automatic write_capacity(input logic [lpc_pkg::CapW-1:0] value);
    settle_pipeline();
    repeat (DrainCycles) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_page(input logic [lpc_pkg::PageNumW-1:0] pg, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         <= 1'b1;
    page_number_i <= pg;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    pinned_valid = 1'b0;
  endtask

  initial begin
    int unsigned ecap;
    int          gap;
    int          pick;
    logic        burst;
    logic [lpc_pkg::CapW-1:0]     cap_val;
    logic [lpc_pkg::PageNumW-1:0] pg;
    rst_ni         = 1'b0;
    start          = 1'b0;
    page_number_i  = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    pinned_valid   = 1'b0;
    pinned_result  = '0;
    error_count    = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    resident       = 0;
    capacity       = lpc_pkg::CapW'(lpc_pkg::CapReset);
    for (int i = 0; i < Entries; i++) begin
      slot_valid[i] = 1'b0;
      age_rank[i]   = 0;
      tag_mem[i]    = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DirectedRows; r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_capacity(directed_rows[r].value[lpc_pkg::CapW-1:0]);
      end else begin
        pinned_valid  = directed_rows[r].pinned;
        pinned_result = directed_rows[r].res;
        send_page(directed_rows[r].value, r % 3);
      end
    end

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: cap_val = 5'd1;
        1: cap_val = 5'd16;
        2: cap_val = 5'd0;
        3: cap_val = 5'd31;
        4: cap_val = 5'd2;
        default: cap_val = lpc_pkg::CapW'($urandom_range(0, 31));
      endcase
      write_capacity(cap_val);
      ecap  = (cap_val == 0) ? 1 : ((cap_val > Entries) ? Entries : cap_val);
      burst = (p % 3 == 1);
      for (int k = 0; k < PoolSize; k++) page_pool[k] = lpc_pkg::PageNumW'($urandom);
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)
          pg = '0;
        else if (pick == 1)
          pg = '1;
        else if (pick < 5)
          pg = lpc_pkg::PageNumW'($urandom);
        else
          pg = page_pool[$urandom_range(0, (ecap + 4 < PoolSize) ? ecap + 4 : PoolSize - 1)];
        gap = burst ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 40) == 0) settle_pipeline();
        send_page(pg, gap);
      end
    end

    settle_pipeline();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && pending_lookups.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+src
src/lpc_pkg.sv
src/lru_page_cache.sv
dv/lru_page_cache_tb.sv
